[design/pfde_pkg.sv]
package pfde_pkg;

    // Field widths of one command item and one result item
    localparam int OP_W    = 3;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 6;
    localparam int SPW_W   = 8;
    localparam int SPH_W   = 7;
    localparam int BYTE_W  = 8;

    // Packed stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 16;

    // Internal coordinate widths: columns reach col + span_w, rows reach row + span_h
    localparam int XW  = 10;
    localparam int YW  = 9;
    localparam int PGW = YW - 3;

    // Upper bound on the size of the byte store
    localparam int STORE_DEPTH = 1024;

    // Command codes
    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL  = 3'd1;
    localparam logic [OP_W-1:0] OP_INV   = 3'd2;
    localparam logic [OP_W-1:0] OP_HSET  = 3'd3;
    localparam logic [OP_W-1:0] OP_HCLR  = 3'd4;
    localparam logic [OP_W-1:0] OP_VLINE = 3'd5;
    localparam logic [OP_W-1:0] OP_RECT  = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

    // Byte update modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_TOGGLE = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       setup;
        logic [1:0] pass_sel;
        logic       rd;
        logic       wr;
        logic       clr;
        logic       load_out;
    } pfde_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic skip;
        logic empty;
        logic is_read;
        logic last_byte;
        logic last_pass;
        logic clr_last;
        logic out_free;
    } pfde_stat_t;

endpackage

[design/pfde_datapath.sv]
module pfde_datapath #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pfde_pkg::pfde_cmd_t                 cmd,
    output pfde_pkg::pfde_stat_t                stat,
    input  logic [pfde_pkg::S_TDATA_W-1:0]      in_data,
    input  logic [pfde_pkg::S_TUSER_W-1:0]      in_user,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pfde_pkg::M_TDATA_W-1:0]      out_data
);
    import pfde_pkg::*;

    localparam int PAGES     = (HEIGHT + 7) / 8;
    localparam int FULL      = PAGES * WIDTH;
    localparam int MEM_DEPTH = (FULL < STORE_DEPTH) ? FULL : STORE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int IW        = PGW + XW;

    // Captured command fields
    logic [OP_W-1:0]   op_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SPW_W-1:0]  w_reg;
    logic [SPH_W-1:0]  h_reg;
    logic [BYTE_W-1:0] fb_reg;

    // Geometry of the current pass
    logic [XW-1:0]  x0_reg, x_stop_reg, x_cur_reg;
    logic [YW-1:0]  y0_reg, yend_reg;
    logic [PGW-1:0] page_cur_reg, page_last_reg;
    logic [1:0]     mode_reg;
    logic           empty_reg;
    logic           ok_reg;

    logic [BYTE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;

    logic [BYTE_W-1:0] frame_store [MEM_DEPTH];

    // Pass table: a rectangle outline is four passes, everything else one
    logic [XW-1:0]    p_x0;
    logic [SPW_W-1:0] p_nx;
    logic [YW-1:0]    p_y0;
    logic [SPH_W-1:0] p_ny;
    logic [1:0]       p_mode;

    always_comb
    begin
        p_x0   = XW'(col_reg);
        p_nx   = w_reg;
        p_y0   = YW'(row_reg);
        p_ny   = h_reg;
        p_mode = MODE_SET;
        case (op_reg)
            OP_READ:
            begin
                p_nx   = SPW_W'(1);
                p_ny   = SPH_W'(1);
                p_mode = MODE_WRITE;
            end
            OP_FILL:  p_mode = MODE_WRITE;
            OP_INV:   p_mode = MODE_TOGGLE;
            OP_HSET:  p_ny   = SPH_W'(1);
            OP_HCLR:
            begin
                p_ny   = SPH_W'(1);
                p_mode = MODE_CLEAR;
            end
            OP_VLINE: p_nx   = SPW_W'(1);
            OP_RECT:
            begin
                case (cmd.pass_sel)
                    2'd0: p_ny = SPH_W'(1);
                    2'd1:
                    begin
                        p_y0 = YW'(row_reg) + YW'(h_reg) - YW'(1);
                        p_ny = SPH_W'(1);
                    end
                    2'd2: p_nx = SPW_W'(1);
                    default:
                    begin
                        p_x0 = XW'(col_reg) + XW'(w_reg) - XW'(1);
                        p_nx = SPW_W'(1);
                    end
                endcase
            end
            default:
            begin
                p_nx = '0;
                p_ny = '0;
            end
        endcase
    end

    // Clip the pass to the screen and work out its page range
    logic [XW-1:0] x_sum, x_stop;
    logic [YW-1:0] y_sum, y_end, y_span, y_last;

    always_comb
    begin
        x_sum  = p_x0 + XW'(p_nx);
        x_stop = (x_sum > XW'(WIDTH)) ? XW'(WIDTH) : x_sum;
        y_sum  = p_y0 + YW'(p_ny);
        y_end  = (y_sum > YW'(HEIGHT)) ? YW'(HEIGHT) : y_sum;
        y_span = y_end - p_y0 - YW'(1);
        // Fill steps a row cursor by eight from the top row, so its page count
        // follows the height and not the pages the rows touch.
        if (p_mode == MODE_WRITE)
            y_last = p_y0 + {y_span[YW-1:3], 3'b000};
        else
            y_last = y_end - YW'(1);
    end

    // Store address and its validity
    logic [IW-1:0] idx;
    logic          addr_ok;

    assign idx     = IW'(page_cur_reg) * IW'(WIDTH) + IW'(x_cur_reg);
    assign addr_ok = (x_cur_reg < XW'(WIDTH)) && (page_cur_reg < PGW'(PAGES))
                     && (idx < IW'(MEM_DEPTH));

    // Row mask within the current page byte and the updated byte
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] new_byte;
    logic [YW-1:0]     row_b;

    always_comb
    begin
        row_b = '0;
        for (int b = 0; b < BYTE_W; b++)
        begin
            row_b   = {page_cur_reg, 3'(b)};
            mask[b] = (row_b >= y0_reg) && (row_b < yend_reg);
        end
        case (mode_reg)
            MODE_WRITE:  new_byte = fb_reg;
            MODE_SET:    new_byte = rd_data_reg | mask;
            MODE_CLEAR:  new_byte = rd_data_reg & ~mask;
            MODE_TOGGLE: new_byte = rd_data_reg ^ mask;
            default:     new_byte = rd_data_reg;
        endcase
    end

    // Command capture and pass registers
    logic x_wrap;
    assign x_wrap = (x_cur_reg + XW'(1)) >= x_stop_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_user[OP_W-1:0];
            col_reg <= in_data[6:0];
            row_reg <= in_data[12:7];
            w_reg   <= in_data[20:13];
            h_reg   <= in_data[27:21];
            fb_reg  <= in_data[35:28];
        end
        if (cmd.setup)
        begin
            x0_reg        <= p_x0;
            x_stop_reg    <= x_stop;
            x_cur_reg     <= p_x0;
            y0_reg        <= p_y0;
            yend_reg      <= y_end;
            page_cur_reg  <= p_y0[YW-1:3];
            page_last_reg <= y_last[YW-1:3];
            mode_reg      <= p_mode;
            empty_reg     <= (x_stop <= p_x0) || (y_end <= p_y0);
        end
        else if (cmd.wr)
        begin
            if (x_wrap)
            begin
                x_cur_reg    <= x0_reg;
                page_cur_reg <= page_cur_reg + PGW'(1);
            end
            else
                x_cur_reg <= x_cur_reg + XW'(1);
        end
        if (cmd.rd)
            ok_reg <= addr_ok;
    end

    // Byte store: one read and one write port, read data registered
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;

    assign mem_we    = cmd.clr || (cmd.wr && (op_reg != OP_READ) && addr_ok);
    assign mem_waddr = cmd.clr ? clr_addr_reg : idx[ADDR_W-1:0];
    assign mem_wdata = cmd.clr ? '0 : new_byte;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_store[mem_waddr] <= mem_wdata;
        if (cmd.rd)
            rd_data_reg <= frame_store[idx[ADDR_W-1:0]];
    end

    // Clearing sweep address and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_data_reg <= ((op_reg == OP_READ) && ok_reg) ? rd_data_reg : '0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {(M_TDATA_W - BYTE_W - 1)'(0), 1'b1, out_data_reg};

    // Status back to the controller
    always_comb
    begin
        stat.skip      = (op_reg == OP_SPARE)
                         || ((op_reg == OP_RECT) && ((w_reg == '0) || (h_reg == '0)))
                         || ((op_reg == OP_INV) && (row_reg[2:0] != 3'd0)
                             && (h_reg < SPH_W'(4'd8 - {1'b0, row_reg[2:0]})));
        stat.empty     = empty_reg;
        stat.is_read   = (op_reg == OP_READ);
        stat.last_byte = x_wrap && (page_cur_reg == page_last_reg);
        stat.last_pass = (op_reg != OP_RECT) || (cmd.pass_sel == 2'd3);
        stat.clr_last  = (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1));
        stat.out_free  = !out_valid_reg || out_ready;
    end

endmodule

[design/pfde_ctrl.sv]
module pfde_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pfde_pkg::pfde_stat_t  stat,
    output pfde_pkg::pfde_cmd_t   cmd
);
    import pfde_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] pass_reg, pass_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pass_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    // Sequencing of passes and read-modify-write steps
    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.pass_sel = pass_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    pass_next   = 2'd0;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.is_read)
                    state_next = S_RD;
                else if (stat.skip)
                    state_next = S_DONE;
                else if (!stat.empty)
                    state_next = S_RD;
                else if (stat.last_pass)
                    state_next = S_DONE;
                else
                begin
                    pass_next  = pass_reg + 2'd1;
                    state_next = S_SETUP;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr = 1'b1;
                if (stat.is_read)
                    state_next = S_DONE;
                else if (!stat.last_byte)
                    state_next = S_RD;
                else if (stat.last_pass)
                    state_next = S_DONE;
                else
                begin
                    pass_next  = pass_reg + 2'd1;
                    state_next = S_SETUP;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

[design/page_framebuffer_draw_engine.sv]
// Channel   Direction  Contents
// s_axis    in         one drawing or read command per item
// m_axis    out        one result per command: read byte and completion flag
//
// A command is taken in S_IDLE; each pass (four passes for an outline, one
// otherwise) is set up in S_SETUP and S_CHECK; each byte visited is a registered
// store read in S_RD, then the write of the updated byte in S_WR; last the result
// is loaded in S_DONE, once the output register is free.
// After reset the store is swept to zero, one byte a cycle, before any item is taken.
// A result waits in an output register; a stalled m_axis holds the engine only
// once the next command has finished.
module page_framebuffer_draw_engine #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // col[6:0], row[12:7], span_w[20:13], span_h[27:21], fill_byte[35:28]
    input  logic [pfde_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // operation[2:0]
    input  logic [pfde_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data[7:0], done_res[8]
    output logic [pfde_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import pfde_pkg::*;

    pfde_cmd_t  cmd;
    pfde_stat_t stat;

    // Command sequencer
    pfde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Geometry, byte store and result register
    pfde_datapath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
